### src/assert_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define PTTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, off during reset
`define PTTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### src/ptts_pkg.sv
// types and constants of the periodic task tick scheduler
package ptts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int MASK_W     = 8;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_SUSPEND = 3'd2,
    MODE_RESUME  = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMD    = 4'b0010,
    S_TICK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] countdown;
  } slot_entry_t;

  // write side of the slot table
  typedef struct packed {
    logic              mem_we;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       entry;
    logic              pres_we;
    logic              pres_val;
    logic              run_we;
    logic              run_val;
  } tbl_wr_t;

  // registered read side of the slot table
  typedef struct packed {
    slot_entry_t entry;
    logic        present;
    logic        running;
  } tbl_rd_t;

  // result of the shared countdown unit
  typedef struct packed {
    logic        we;
    logic        fire;
    logic [15:0] countdown;
  } cd_res_t;

endpackage

### src/ptts_if.sv
// request and result channel interfaces
interface ptts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  task_index;
  logic [15:0] period;
  logic [15:0] first_delay;

  modport source (output valid, mode, task_index, period, first_delay, input ready);
  modport sink   (input valid, mode, task_index, period, first_delay, output ready);
endinterface

interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] fire_mask;
  logic       accepted;

  modport source (output valid, fire_mask, accepted, input ready);
  modport sink   (input valid, fire_mask, accepted, output ready);
endinterface

### src/ptts_slot_table.sv
// slot table: period/countdown memory plus present and running flags
module ptts_slot_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptts_pkg::tbl_wr_t                 wr_i,
  input  logic                              rd_en_i,
  input  logic [ptts_pkg::SLOT_W-1:0]       rd_addr_i,
  output ptts_pkg::tbl_rd_t                 rd_o
);

  ptts_pkg::slot_entry_t              mem_q [ptts_pkg::SLOT_COUNT];
  logic [ptts_pkg::SLOT_COUNT-1:0]    present_q;
  logic [ptts_pkg::SLOT_COUNT-1:0]    running_q;
  ptts_pkg::tbl_rd_t                  rd_q;

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.mem_we) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rd_q.entry   <= mem_q[rd_addr_i];
      rd_q.present <= present_q[rd_addr_i];
      rd_q.running <= running_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (wr_i.pres_we) begin
      present_q[wr_i.addr] <= wr_i.pres_val;
    end
  end

  // running flag is meaningful only once the slot was written
  always_ff @(posedge clk_i) begin
    if (wr_i.run_we) begin
      running_q[wr_i.addr] <= wr_i.run_val;
    end
  end

  assign rd_o = rd_q;

endmodule

### src/ptts_cd_unit.sv
// shared countdown unit: one decrementer for reload and countdown
module ptts_cd_unit (
  input  ptts_pkg::tbl_rd_t slot_i,
  output ptts_pkg::cd_res_t res_o
);

  logic        at_zero;
  logic [15:0] operand;
  logic [15:0] dec;

  // at zero the period feeds the decrementer, period zero reloads zero
  assign at_zero = slot_i.entry.countdown == 16'd0;
  assign operand = at_zero ? slot_i.entry.period : slot_i.entry.countdown;
  assign dec     = (operand == 16'd0) ? 16'd0 : operand - 16'd1;

  always_comb begin
    res_o.we        = slot_i.present;
    res_o.fire      = slot_i.present && at_zero && slot_i.running;
    res_o.countdown = dec;
    if (at_zero && !slot_i.running) begin
      res_o.countdown = 16'd0; // suspended slot holds at zero
    end
  end

endmodule

### src/periodic_task_tick_scheduler.sv
// top level of the periodic task tick scheduler
`include "assert_macros.svh"

// Time-triggered task scheduler with SLOT_COUNT slots (8). Each request is a tick or
// a command (create, suspend, resume, delete) on one slot, and returns exactly one
// result with the fire mask of the tick and an accepted flag. One request is
// handled at a time; in_i.ready is high only while the block is idle. A command passes
// through the S_CMD and S_FINISH states into the output register. A tick walks the slot
// table one slot per cycle through the single read port of the table memory and
// the shared countdown decrementer, then goes through S_FINISH into the output register.
// The result register is held until taken; a full result register delays the end of
// the next request, not its acceptance. Every slot has a fire mask bit, since
// MASK_W equals SLOT_COUNT. No clearing pass is needed after reset.
module periodic_task_tick_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptts_in_if.sink     in_i,
  ptts_out_if.source  out_o
);

  ptts_pkg::state_e                 state_q, state_d;
  ptts_pkg::mode_e                  cmd_mode_q;
  logic [7:0]                       cmd_idx_q;
  logic [15:0]                      cmd_period_q;
  logic [15:0]                      cmd_delay_q;
  logic                             cmd_ok;

  // tick walk: read index and one stage of slot in flight
  logic [ptts_pkg::CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                             rd_issue;
  logic [ptts_pkg::SLOT_W-1:0]      rd_addr;
  logic                             stage_vld_q;
  logic [ptts_pkg::SLOT_W-1:0]      stage_idx_q;

  logic [ptts_pkg::MASK_W-1:0]      mask_q, mask_d;
  logic                             acc_q, acc_d;

  // result register
  logic                             out_valid_q;
  logic [ptts_pkg::MASK_W-1:0]      fire_mask_q;
  logic                             accepted_q;
  logic                             out_load;

  ptts_pkg::tbl_wr_t                tbl_wr;
  ptts_pkg::tbl_rd_t                tbl_rd;
  ptts_pkg::cd_res_t                cd_res;

  logic                             in_acc;
  logic                             in_is_tick;

  assign in_i.ready = state_q == ptts_pkg::S_IDLE;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_is_tick = in_i.mode == ptts_pkg::MODE_TICK;

  assign rd_issue = (state_q == ptts_pkg::S_TICK)
                    && (rd_idx_q != ptts_pkg::CNT_W'(ptts_pkg::SLOT_COUNT));
  assign rd_addr  = rd_idx_q[ptts_pkg::SLOT_W-1:0];

  // command check: defined command code and slot in range
  always_comb begin
    case (cmd_mode_q) inside
      ptts_pkg::MODE_CREATE, ptts_pkg::MODE_SUSPEND,
      ptts_pkg::MODE_RESUME, ptts_pkg::MODE_DELETE:
        cmd_ok = 32'(cmd_idx_q) < ptts_pkg::SLOT_COUNT;
      default: cmd_ok = 1'b0;
    endcase
  end

  ptts_slot_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_en_i   (rd_issue),
    .rd_addr_i (rd_addr),
    .rd_o      (tbl_rd)
  );

  ptts_cd_unit u_cd (
    .slot_i (tbl_rd),
    .res_o  (cd_res)
  );

  // table writes: tick write-back or a command, never both
  always_comb begin
    tbl_wr = '0;
    if (stage_vld_q) begin
      tbl_wr.mem_we           = cd_res.we;
      tbl_wr.addr             = stage_idx_q;
      tbl_wr.entry.period     = tbl_rd.entry.period;
      tbl_wr.entry.countdown  = cd_res.countdown;
    end else if (state_q == ptts_pkg::S_CMD && cmd_ok) begin
      tbl_wr.addr                = cmd_idx_q[ptts_pkg::SLOT_W-1:0];
      tbl_wr.entry.period        = cmd_period_q;
      tbl_wr.entry.countdown     = cmd_delay_q;
      unique case (cmd_mode_q)
        ptts_pkg::MODE_CREATE: begin
          tbl_wr.mem_we   = 1'b1;
          tbl_wr.pres_we  = 1'b1;
          tbl_wr.pres_val = 1'b1;
          tbl_wr.run_we   = 1'b1;
          tbl_wr.run_val  = 1'b1;
        end
        ptts_pkg::MODE_SUSPEND: begin
          tbl_wr.run_we  = 1'b1;
          tbl_wr.run_val = 1'b0;
        end
        ptts_pkg::MODE_RESUME: begin
          tbl_wr.run_we  = 1'b1;
          tbl_wr.run_val = 1'b1;
        end
        ptts_pkg::MODE_DELETE: begin
          tbl_wr.pres_we  = 1'b1;
          tbl_wr.pres_val = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // fire mask collects one slot per cycle, only the low eight slots have a bit
  always_comb begin
    mask_d = mask_q;
    for (int j = 0; j < ptts_pkg::MASK_W; j++) begin
      if (stage_vld_q && cd_res.fire && (32'(stage_idx_q) == j)) begin
        mask_d[j] = 1'b1;
      end
    end
    if (in_acc) begin
      mask_d = '0;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    acc_d    = acc_q;
    out_load = 1'b0;
    unique case (state_q)
      ptts_pkg::S_IDLE: begin
        if (in_acc) begin
          rd_idx_d = '0;
          state_d  = in_is_tick ? ptts_pkg::S_TICK : ptts_pkg::S_CMD;
        end
      end
      ptts_pkg::S_CMD: begin
        acc_d   = cmd_ok;
        state_d = ptts_pkg::S_FINISH;
      end
      ptts_pkg::S_TICK: begin
        acc_d = 1'b1;
        if (rd_issue) begin
          rd_idx_d = rd_idx_q + ptts_pkg::CNT_W'(1);
        end else if (!stage_vld_q) begin
          state_d = ptts_pkg::S_FINISH;
        end
      end
      ptts_pkg::S_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ptts_pkg::S_IDLE;
        end
      end
      default: state_d = ptts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptts_pkg::S_IDLE;
      rd_idx_q    <= '0;
      stage_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      stage_vld_q <= rd_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stage_idx_q <= rd_addr;
    mask_q      <= mask_d;
    acc_q       <= acc_d;
    if (in_acc) begin
      cmd_mode_q   <= ptts_pkg::mode_e'(in_i.mode);
      cmd_idx_q    <= in_i.task_index;
      cmd_period_q <= in_i.period;
      cmd_delay_q  <= in_i.first_delay;
    end
    if (out_load) begin
      fire_mask_q <= mask_q;
      accepted_q  <= acc_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.fire_mask = fire_mask_q;
  assign out_o.accepted  = accepted_q;

  `PTTS_ASSERT_NOW(a_stage_in_range, clk_i, rst_ni, stage_vld_q,
                   32'(stage_idx_q) < ptts_pkg::SLOT_COUNT)
  `PTTS_ASSERT_NOW(a_reject_no_fire, clk_i, rst_ni, out_valid_q && !accepted_q,
                   fire_mask_q == '0)
  `PTTS_ASSERT_NOW(a_walk_only_in_tick, clk_i, rst_ni, stage_vld_q,
                   state_q == ptts_pkg::S_TICK)
  `PTTS_ASSERT_NEXT(a_walk_ends, clk_i, rst_ni,
                    state_q == ptts_pkg::S_TICK && !rd_issue && !stage_vld_q,
                    state_q == ptts_pkg::S_FINISH)

endmodule

### sim/tb_periodic_task_tick_scheduler.sv
// self-checking testbench for the periodic task tick scheduler
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  // request and result as the testbench sees them
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  task_index;
    logic [15:0] period;
    logic [15:0] first_delay;
  } sched_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic              accepted;
  } sched_res_t;

  localparam int MODE_CODE_MAX  = 7;       // highest code the mode field can carry
  localparam int IDX_MAX        = 255;
  localparam int FIELD_MAX      = 65535;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int TICK_CYCLES    = SLOT_COUNT + 3;
  localparam int DRAIN_CYCLES   = 2 * TICK_CYCLES + 8;
  localparam int HOLD_AT_RESULT = 300;     // result count that starts the long hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;    // cycles without any handshake

  logic clk = 1'b0;
  logic rst_n;

  ptts_in_if  req_if ();
  ptts_out_if res_if ();

  periodic_task_tick_scheduler u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the task table, updated as each request is taken
  logic        task_present [SLOT_COUNT];
  logic        task_running [SLOT_COUNT];
  logic [15:0] task_period  [SLOT_COUNT];
  logic [15:0] task_count   [SLOT_COUNT];

  sched_req_t request_q[$];   // requests not yet offered to the block
  sched_res_t outcome_q[$];   // predicted results, oldest first

  int  mismatches   = 0;
  int  results_seen = 0;
  int  idle_cycles  = 0;
  bit  req_taken    = 1'b0;   // set at the edge that takes the offered request
  int  send_gap     = 0;
  int  send_calm    = 0;
  int  recv_stall   = 0;
  int  recv_calm    = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;

  // advance the shadow table by one request and return the result it must give
  function automatic sched_res_t apply_request(sched_req_t rq);
    sched_res_t res;
    res = '0;
    if (rq.mode == MODE_TICK) begin
      res.accepted = 1'b1;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (task_present[s]) begin
          if (task_count[s] != 16'd0) begin
            task_count[s] = task_count[s] - 16'd1;
          end else if (task_running[s]) begin
            // a zero period behaves as one, so it reloads to zero
            task_count[s] = (task_period[s] == 16'd0) ? 16'd0 : task_period[s] - 16'd1;
            if (s < MASK_W) res.fire_mask[s] = 1'b1;
          end
          // suspended at zero: holds, no wrap
        end
      end
    end else if (rq.mode <= MODE_DELETE && rq.task_index < SLOT_COUNT) begin
      // commands on an absent slot still write their bit
      res.accepted = 1'b1;
      case (rq.mode)
        MODE_CREATE: begin
          task_period[rq.task_index]  = rq.period;
          task_count[rq.task_index]   = rq.first_delay;
          task_running[rq.task_index] = 1'b1;
          task_present[rq.task_index] = 1'b1;
        end
        MODE_SUSPEND: task_running[rq.task_index] = 1'b0;
        MODE_RESUME:  task_running[rq.task_index] = 1'b1;
        default:      task_present[rq.task_index] = 1'b0;
      endcase
    end
    // out-of-range slot and unused modes leave the table alone
    return res;
  endfunction

  function automatic sched_req_t make_req(logic [2:0] mode, int idx, int per, int dly);
    sched_req_t rq;
    rq.mode        = mode;
    rq.task_index  = idx[7:0];
    rq.period      = per[15:0];
    rq.first_delay = dly[15:0];
    return rq;
  endfunction

  // idle length: mostly none or short, now and then long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // slot index that is nearly always in range
  function automatic int pick_slot();
    if ($urandom_range(0, 19) == 0) return $urandom_range(SLOT_COUNT, IDX_MAX);
    return $urandom_range(0, SLOT_COUNT - 1);
  endfunction

  // short periods and delays keep slots firing; a few use the full range
  function automatic int pick_ticks(int short_max);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, short_max);
    return $urandom_range(0, FIELD_MAX);
  endfunction

  // request driver: changes inputs at the falling edge, holds until taken
  always @(negedge clk) begin : drive_requests
    sched_req_t nxt;
    if (rst_n && (!req_if.valid || req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        req_if.mode        <= nxt.mode;
        req_if.task_index  <= nxt.task_index;
        req_if.period      <= nxt.period;
        req_if.first_delay <= nxt.first_delay;
        req_if.valid       <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result ready: random stalls, plus one long hold-off so the block
  // fills up and has to refuse requests
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        recv_stall = pick_gap(recv_calm);
      end
    end
  end

  // monitor: checks results, predicts taken requests, and guards against hangs
  always @(posedge clk) begin : monitor
    sched_res_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n && res_if.valid && res_if.ready) begin
      moved = 1'b1;
      results_seen++;
      if (outcome_q.size() == 0) begin
        $display("%0t: result with none expected: fire_mask %h accepted %b",
                 $time, res_if.fire_mask, res_if.accepted);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (res_if.fire_mask !== want.fire_mask) begin
          $display("%0t: fire_mask expected %h actual %h",
                   $time, want.fire_mask, res_if.fire_mask);
          mismatches++;
        end
        if (res_if.accepted !== want.accepted) begin
          $display("%0t: accepted expected %b actual %b",
                   $time, want.accepted, res_if.accepted);
          mismatches++;
        end
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      moved = 1'b1;
      outcome_q.push_back(apply_request(make_req(req_if.mode, req_if.task_index,
                                                 req_if.period, req_if.first_delay)));
      req_taken = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_periodic_task_tick_scheduler NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int counted;
    int r;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_TICK;
    req_if.task_index  = '0;
    req_if.period      = '0;
    req_if.first_delay = '0;
    res_if.ready       = 1'b0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      task_present[s] = 1'b0;
      task_running[s] = 1'b0;
      task_period[s]  = '0;
      task_count[s]   = '0;
    end

    // directed: empty table, extremes, suspend hold, bad slots, absent slots, unused modes
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(MODE_CREATE, 0, 0, 0));              // period zero
    request_q.push_back(make_req(MODE_CREATE, SLOT_COUNT - 1, FIELD_MAX, 1));
    request_q.push_back(make_req(MODE_CREATE, 3, 2, FIELD_MAX));
    request_q.push_back(make_req(MODE_TICK, IDX_MAX, FIELD_MAX, FIELD_MAX));
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(MODE_SUSPEND, 0, 0, 0));             // held at zero
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(MODE_RESUME, 0, 0, 0));
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(MODE_CREATE, 5, 1, 0));
    request_q.push_back(make_req(MODE_SUSPEND, 5, 0, 0));
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(MODE_CREATE, SLOT_COUNT, 1, 0));     // slot out of range
    request_q.push_back(make_req(MODE_CREATE, IDX_MAX, FIELD_MAX, FIELD_MAX));
    request_q.push_back(make_req(MODE_SUSPEND, IDX_MAX, 0, 0));
    request_q.push_back(make_req(MODE_SUSPEND, 6, 0, 0));             // absent slot
    request_q.push_back(make_req(MODE_RESUME, 6, 0, 0));
    request_q.push_back(make_req(MODE_DELETE, 6, 0, 0));
    request_q.push_back(make_req(MODE_DELETE, SLOT_COUNT - 1, 0, 0));
    request_q.push_back(make_req(MODE_TICK, 0, 0, 0));
    for (int m = int'(MODE_DELETE) + 1; m <= MODE_CODE_MAX; m++)
      request_q.push_back(make_req(3'(m), IDX_MAX, FIELD_MAX, FIELD_MAX));

    // random: mostly ticks and valid commands on short timers, some noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        request_q.push_back(make_req(MODE_TICK, $urandom_range(0, IDX_MAX),
                                     $urandom_range(0, FIELD_MAX),
                                     $urandom_range(0, FIELD_MAX)));
        counted++;
      end else if (r < 70) begin
        request_q.push_back(make_req(MODE_CREATE, pick_slot(), pick_ticks(6),
                                     pick_ticks(8)));
        counted++;
      end else if (r < 93) begin
        request_q.push_back(make_req((r < 78) ? MODE_SUSPEND :
                                     (r < 86) ? MODE_RESUME : MODE_DELETE,
                                     pick_slot(), $urandom_range(0, FIELD_MAX),
                                     $urandom_range(0, FIELD_MAX)));
        counted++;
      end else if (r < 97) begin
        // command on a slot that does not exist
        request_q.push_back(make_req(3'($urandom_range(MODE_CREATE, MODE_DELETE)),
                                     $urandom_range(SLOT_COUNT, IDX_MAX),
                                     $urandom_range(0, FIELD_MAX),
                                     $urandom_range(0, FIELD_MAX)));
      end else begin
        // unused mode
        request_q.push_back(make_req(3'($urandom_range(int'(MODE_DELETE) + 1,
                                                       MODE_CODE_MAX)),
                                     $urandom_range(0, IDX_MAX),
                                     $urandom_range(0, FIELD_MAX),
                                     $urandom_range(0, FIELD_MAX)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // everything offered and taken, then every result back, then a short drain
    while (request_q.size() != 0 || req_if.valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_periodic_task_tick_scheduler OK");
    end else begin
      $display("tb_periodic_task_tick_scheduler NOT OK");
    end
    $finish;
  end

endmodule
